[hw/rtl/psbs_pkg.sv]
// ----------------------------------------------------------------------------
// psbs_pkg
// Shared types, widths and slot mapping for the polynomial background
// subtraction engine.
// ----------------------------------------------------------------------------
package psbs_pkg;

	localparam int PWR_W  = 32;   // power of a normalized coordinate, signed Q2.30
	localparam int NORM_W = 31;   // normalized coordinate, signed Q1.30
	localparam int COEF_W = 32;   // coefficient, signed Q8.24
	localparam int TERM_W = 34;   // one coefficient times monomial, signed Q10.24

	localparam logic signed [PWR_W-1:0] ONE_Q30 = 32'sh4000_0000;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PIXEL = 1'b1
	} psbs_cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ORDER  = 2'd0,
		REG_XSCALE = 2'd1,
		REG_YSCALE = 2'd2,
		REG_OFFSET = 2'd3
	} psbs_reg_t;

	// Item fields that travel along the pipeline with every transaction
	typedef struct packed {
		psbs_cmd_t          cmd;
		logic [3:0]         coeff_index;
		logic [COEF_W-1:0]  coeff_value;
		logic [31:0]        pixel_value;
	} psbs_tag_t;

	// Store slot of monomial x^i y^j for a given order: x-power outer, y-power inner
	function automatic int lane_slot(input int i, input int j, input int o);
		return i * (o + 1) - (i * (i - 1)) / 2 + j;
	endfunction

endpackage

[hw/rtl/poly_surface_background_subtract.sv]
// ----------------------------------------------------------------------------
// poly_surface_background_subtract
// Streaming 2D polynomial background subtraction.
// ----------------------------------------------------------------------------
// The engine takes one transaction per clock while in_stall is low, load or
// pixel, and returns one result per pixel. The depth of 7 + MAX_ORDER stages
// is set by the chain of power cells (one cell per power of the coordinates)
// plus two normalize stages, two multiply stages per monomial lane, a
// two-level adder tree and the output register. Loads travel down the same
// pipeline and write the coefficient store in the stage where pixels read it,
// so every pixel sees exactly the loads that came before it. Empty stages
// collapse under a stall, so transactions keep entering until the pipeline
// is full. Configuration writes are always taken.
module poly_surface_background_subtract
	import psbs_pkg::*;
#(
	parameter int MAX_ORDER  = 4,
	parameter int COORD_BITS = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [3:0]             coeff_index,
	input  logic signed [31:0]     coeff_value,
	input  logic [COORD_BITS-1:0]  pix_x,
	input  logic [COORD_BITS-1:0]  pix_y,
	input  logic signed [31:0]     pixel_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     corrected_value,
	output logic                   saturated,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam int NUM_COEFF = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
	localparam int SLOT_W    = (NUM_COEFF > 1) ? $clog2(NUM_COEFF) : 1;
	localparam int NGRP      = (NUM_COEFF + 3) / 4;
	localparam int PART_W    = TERM_W + 2;
	localparam int SUM_W     = TERM_W + $clog2(NUM_COEFF + 1);
	localparam int RES_W     = SUM_W + 2;
	localparam int PROD_W    = COORD_BITS + 31;

	// stage numbers
	localparam int ST_A = 3 + MAX_ORDER;
	localparam int ST_B = 4 + MAX_ORDER;
	localparam int ST_C = 5 + MAX_ORDER;
	localparam int ST_D = 6 + MAX_ORDER;
	localparam int NS   = 7 + MAX_ORDER;

	localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(64'sd2147483647);
	localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-64'sd2147483648);

	// configuration
	logic [2:0]          poly_order_q;
	logic [30:0]         x_scale_q;
	logic [30:0]         y_scale_q;
	logic signed [31:0]  offset_add_q;
	logic [2:0]          ord_eff;

	// handshake
	logic [NS:1] v_q;
	logic [NS:1] en;

	// normalize stages
	psbs_tag_t              tag_s1;
	logic [PROD_W-1:0]      xprod_s1;
	logic [PROD_W-1:0]      yprod_s1;
	psbs_tag_t              tag_s2;
	logic signed [NORM_W-1:0] xn_s2;
	logic signed [NORM_W-1:0] yn_s2;

	// power chain, index 0 is the normalize output
	psbs_tag_t                       tag_c [0:MAX_ORDER];
	logic signed [NORM_W-1:0]        xn_c  [0:MAX_ORDER];
	logic signed [NORM_W-1:0]        yn_c  [0:MAX_ORDER];
	logic [MAX_ORDER:0][PWR_W-1:0]   xp_c  [0:MAX_ORDER];
	logic [MAX_ORDER:0][PWR_W-1:0]   yp_c  [0:MAX_ORDER];

	// lanes and sum
	logic [NUM_COEFF-1:0][COEF_W-1:0] store_q;
	logic signed [TERM_W-1:0]         terms [0:NUM_COEFF-1];
	psbs_tag_t                        tag_s3;
	psbs_tag_t                        tag_s4;
	psbs_tag_t                        tag_s5;
	psbs_tag_t                        tag_s6;
	logic signed [PART_W-1:0]         part_s5 [0:NGRP-1];
	logic signed [PART_W-1:0]         part_nx [0:NGRP-1];
	logic signed [SUM_W-1:0]          bkg_s6;
	logic signed [SUM_W-1:0]          bkg_nx;

	logic signed [RES_W-1:0]          res;
	logic signed [31:0]               out_value_q;
	logic                             out_sat_q;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= 3'd2;
			x_scale_q    <= 31'd2097152;
			y_scale_q    <= 31'd2097152;
			offset_add_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORDER:  poly_order_q <= cfg_data[2:0];
				REG_XSCALE: x_scale_q    <= cfg_data[30:0];
				REG_YSCALE: y_scale_q    <= cfg_data[30:0];
				REG_OFFSET: offset_add_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign ord_eff = (poly_order_q > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : poly_order_q;

	// ------------------------------------------------------------------
	// stage advance: a stage loads when it is empty or its successor loads
	// ------------------------------------------------------------------
	always_comb begin
		en[NS] = !v_q[NS] || !out_stall;
		for (int s = NS - 1; s >= 1; s--) begin
			en[s] = !v_q[s] || en[s+1];
		end
	end

	assign in_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= in_valid;
			end
			for (int s = 2; s < NS; s++) begin
				if (en[s]) begin
					v_q[s] <= v_q[s-1];
				end
			end
			// drop loads here: they produce no result
			if (en[NS]) begin
				v_q[NS] <= v_q[ST_D] && (tag_s6.cmd == CMD_PIXEL);
			end
		end
	end

	// ------------------------------------------------------------------
	// coordinate normalization: coord * scale - 1, saturated to Q1.30
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en[1]) begin
			tag_s1.cmd         <= psbs_cmd_t'(command);
			tag_s1.coeff_index <= coeff_index;
			tag_s1.coeff_value <= coeff_value;
			tag_s1.pixel_value <= pixel_value;
			xprod_s1 <= PROD_W'(pix_x) * PROD_W'(x_scale_q);
			yprod_s1 <= PROD_W'(pix_y) * PROD_W'(y_scale_q);
		end
		if (en[2]) begin
			tag_s2 <= tag_s1;
			xn_s2  <= (xprod_s1 >= PROD_W'(64'h8000_0000)) ? 31'sh3FFF_FFFF
			        : $signed(31'(xprod_s1[30:0] - 31'h4000_0000));
			yn_s2  <= (yprod_s1 >= PROD_W'(64'h8000_0000)) ? 31'sh3FFF_FFFF
			        : $signed(31'(yprod_s1[30:0] - 31'h4000_0000));
		end
	end

	// ------------------------------------------------------------------
	// power chain
	// ------------------------------------------------------------------
	always_comb begin
		tag_c[0] = tag_s2;
		xn_c[0]  = xn_s2;
		yn_c[0]  = yn_s2;
		xp_c[0]  = '0;
		yp_c[0]  = '0;
		xp_c[0][0] = ONE_Q30;
		yp_c[0][0] = ONE_Q30;
	end

	for (genvar gc = 1; gc <= MAX_ORDER; gc++) begin : g_pow
		psbs_pow_cell #(
			.MAX_ORDER (MAX_ORDER),
			.CELL_IDX  (gc)
		) u_cell (
			.clk     (clk),
			.en      (en[2+gc]),
			.tag_in  (tag_c[gc-1]),
			.xn_in   (xn_c[gc-1]),
			.yn_in   (yn_c[gc-1]),
			.xp_in   (xp_c[gc-1]),
			.yp_in   (yp_c[gc-1]),
			.tag_out (tag_c[gc]),
			.xn_out  (xn_c[gc]),
			.yn_out  (yn_c[gc]),
			.xp_out  (xp_c[gc]),
			.yp_out  (yp_c[gc])
		);
	end

	// ------------------------------------------------------------------
	// coefficient store: written where the lanes read it
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (en[ST_B] && v_q[ST_A] && (tag_s3.cmd == CMD_LOAD)
		             && ({2'b00, tag_s3.coeff_index} < 6'(NUM_COEFF))) begin
			store_q[SLOT_W'(tag_s3.coeff_index)] <= tag_s3.coeff_value;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_A]) tag_s3 <= tag_c[MAX_ORDER];
		if (en[ST_B]) tag_s4 <= tag_s3;
		if (en[ST_C]) tag_s5 <= tag_s4;
		if (en[ST_D]) tag_s6 <= tag_s5;
	end

	// ------------------------------------------------------------------
	// monomial lanes, one per (i, j) with i + j <= MAX_ORDER
	// ------------------------------------------------------------------
	for (genvar gi = 0; gi <= MAX_ORDER; gi++) begin : g_xpow
		for (genvar gj = 0; gj <= MAX_ORDER - gi; gj++) begin : g_ypow
			localparam int LN = lane_slot(gi, gj, MAX_ORDER);
			logic signed [COEF_W-1:0] coef;

			// slot meaning follows the current order; lanes above it add nothing
			always_comb begin
				coef = '0;
				for (int o = 0; o <= MAX_ORDER; o++) begin
					if ((int'(ord_eff) == o) && (gi + gj <= o)) begin
						coef = $signed(store_q[SLOT_W'((gi + gj <= o)
						        ? lane_slot(gi, gj, o) : 0)]);
					end
				end
			end

			psbs_term_cell u_term (
				.clk  (clk),
				.en_a (en[ST_A]),
				.en_b (en[ST_B]),
				.xp   (xp_c[MAX_ORDER][gi]),
				.yp   (yp_c[MAX_ORDER][gj]),
				.coef (coef),
				.term (terms[LN])
			);
		end
	end

	// ------------------------------------------------------------------
	// adder tree: groups of four, then the group sums
	// ------------------------------------------------------------------
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			part_nx[g] = '0;
			for (int e = 0; e < 4; e++) begin
				if (4 * g + e < NUM_COEFF) begin
					part_nx[g] = part_nx[g] + PART_W'(terms[4 * g + e]);
				end
			end
		end
	end

	always_comb begin
		bkg_nx = '0;
		for (int g = 0; g < NGRP; g++) begin
			bkg_nx = bkg_nx + SUM_W'(part_s5[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_C]) part_s5 <= part_nx;
		if (en[ST_D]) bkg_s6  <= bkg_nx;
	end

	// ------------------------------------------------------------------
	// subtract, restore offset, saturate
	// ------------------------------------------------------------------
	assign res = RES_W'($signed(tag_s6.pixel_value)) - RES_W'(bkg_s6)
	           + RES_W'(offset_add_q);

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (res > RES_MAX) begin
				out_value_q <= 32'sh7FFF_FFFF;
				out_sat_q   <= 1'b1;
			end else if (res < RES_MIN) begin
				out_value_q <= 32'sh8000_0000;
				out_sat_q   <= 1'b1;
			end else begin
				out_value_q <= res[31:0];
				out_sat_q   <= 1'b0;
			end
		end
	end

	assign out_valid       = v_q[NS];
	assign corrected_value = out_value_q;
	assign saturated       = out_sat_q;

`ifndef NO_ASSERTIONS
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_pixel_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_q[ST_D] && (tag_s6.cmd == CMD_PIXEL)))
		else $error("result without a pixel transaction");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(corrected_value == 32'sh7FFF_FFFF) || (corrected_value == 32'sh8000_0000))
		else $error("saturation flag with unclipped value");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value_q))
		else $error("stalled result lost");
`endif

endmodule

[hw/rtl/psbs_pow_cell.sv]
// ----------------------------------------------------------------------------
// psbs_pow_cell
// One cell of the power chain: forms the next power of both normalized
// coordinates and hands all powers so far to its neighbor.
// ----------------------------------------------------------------------------
module psbs_pow_cell
	import psbs_pkg::*;
#(
	parameter int MAX_ORDER = 4,
	parameter int CELL_IDX  = 1
) (
	input  logic                            clk,
	input  logic                            en,
	input  psbs_tag_t                       tag_in,
	input  logic signed [NORM_W-1:0]        xn_in,
	input  logic signed [NORM_W-1:0]        yn_in,
	input  logic [MAX_ORDER:0][PWR_W-1:0]   xp_in,
	input  logic [MAX_ORDER:0][PWR_W-1:0]   yp_in,
	output psbs_tag_t                       tag_out,
	output logic signed [NORM_W-1:0]        xn_out,
	output logic signed [NORM_W-1:0]        yn_out,
	output logic [MAX_ORDER:0][PWR_W-1:0]   xp_out,
	output logic [MAX_ORDER:0][PWR_W-1:0]   yp_out
);

	logic signed [2*PWR_W-2:0] xprod;
	logic signed [2*PWR_W-2:0] yprod;
	logic [MAX_ORDER:0][PWR_W-1:0]  xp_nx;
	logic [MAX_ORDER:0][PWR_W-1:0]  yp_nx;

	psbs_tag_t                      tag_q;
	logic signed [NORM_W-1:0]       xn_q;
	logic signed [NORM_W-1:0]       yn_q;
	logic [MAX_ORDER:0][PWR_W-1:0]  xp_q;
	logic [MAX_ORDER:0][PWR_W-1:0]  yp_q;

	assign xprod = (2*PWR_W-1)'($signed(xp_in[CELL_IDX-1])) * (2*PWR_W-1)'(xn_in);
	assign yprod = (2*PWR_W-1)'($signed(yp_in[CELL_IDX-1])) * (2*PWR_W-1)'(yn_in);

	always_comb begin
		xp_nx = xp_in;
		yp_nx = yp_in;
		// floor shift by 30: the slice drops the low bits of a two's complement product
		xp_nx[CELL_IDX] = xprod[PWR_W+29:30];
		yp_nx[CELL_IDX] = yprod[PWR_W+29:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= tag_in;
			xn_q  <= xn_in;
			yn_q  <= yn_in;
			xp_q  <= xp_nx;
			yp_q  <= yp_nx;
		end
	end

	assign tag_out = tag_q;
	assign xn_out  = xn_q;
	assign yn_out  = yn_q;
	assign xp_out  = xp_q;
	assign yp_out  = yp_q;

endmodule

[hw/rtl/psbs_term_cell.sv]
// ----------------------------------------------------------------------------
// psbs_term_cell
// One monomial lane: x power times y power, then times its coefficient,
// each product floored to Q2.30 resp. Q10.24.
// ----------------------------------------------------------------------------
module psbs_term_cell
	import psbs_pkg::*;
(
	input  logic                     clk,
	input  logic                     en_a,
	input  logic                     en_b,
	input  logic [PWR_W-1:0]         xp,
	input  logic [PWR_W-1:0]         yp,
	input  logic signed [COEF_W-1:0] coef,
	output logic signed [TERM_W-1:0] term
);

	logic signed [2*PWR_W-1:0]  mono_prod;
	logic signed [2*PWR_W-1:0]  term_prod;
	logic signed [PWR_W-1:0]    mono_s1;
	logic signed [TERM_W-1:0]   term_s2;

	assign mono_prod = (2*PWR_W)'($signed(xp)) * (2*PWR_W)'($signed(yp));
	assign term_prod = (2*PWR_W)'(coef) * (2*PWR_W)'(mono_s1);

	always_ff @(posedge clk) begin
		if (en_a) begin
			mono_s1 <= mono_prod[PWR_W+29:30];
		end
		if (en_b) begin
			term_s2 <= term_prod[2*PWR_W-1:30];
		end
	end

	assign term = term_s2;

endmodule
